// ===== sv/mbe_pkg.sv =====
// Shared constants, types and the saturating helper function of the Mandelbrot escape-time block.
package mbe_pkg;

	localparam int IMAGE_SIZE    = 256;
	localparam int FRACTION_BITS = 28;

	localparam int Q_W    = 32;
	localparam int PIX_W  = 8;
	localparam int CNT_W  = 8;
	localparam int STEP_W = 31;
	localparam int IDX_W  = 2;

	localparam int HALF   = IMAGE_SIZE / 2;
	localparam int OFS_W  = (($clog2(IMAGE_SIZE) > PIX_W) ? $clog2(IMAGE_SIZE) : PIX_W) + 1;
	localparam int PROD_W = OFS_W + STEP_W + 1;
	localparam int P_W    = 2 * Q_W;
	localparam int SQ_W   = P_W - FRACTION_BITS;
	localparam int XR_W   = SQ_W + 1;
	localparam int WIDE_W = P_W + 8;
	localparam int DCNT_W = $clog2(CNT_W);

	localparam logic [DCNT_W-1:0] DIV_LAST = DCNT_W'(CNT_W - 1);

	localparam logic signed [WIDE_W-1:0] FOUR = WIDE_W'(4) <<< FRACTION_BITS;
	localparam logic signed [WIDE_W-1:0] QMAX = (WIDE_W'(1) <<< (Q_W - 1)) - WIDE_W'(1);
	localparam logic signed [WIDE_W-1:0] QMIN = -(WIDE_W'(1) <<< (Q_W - 1));

	localparam logic signed [Q_W-1:0]    RST_CENTRE_REAL = -32'sd201326592;
	localparam logic signed [Q_W-1:0]    RST_CENTRE_IMAG = '0;
	localparam logic        [STEP_W-1:0] RST_PIXEL_STEP  = 31'd2796203;
	localparam logic        [CNT_W-1:0]  RST_MAX_ITER    = 8'd50;

	typedef enum logic [IDX_W-1:0] {
		REG_CENTRE_REAL,
		REG_CENTRE_IMAG,
		REG_PIXEL_STEP,
		REG_MAX_ITER
	} cfg_idx_t;

	typedef struct packed {
		logic signed [Q_W-1:0]    centre_real;
		logic signed [Q_W-1:0]    centre_imag;
		logic        [STEP_W-1:0] pixel_step;
		logic        [CNT_W-1:0]  max_iterations;
	} cfg_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMUL,
		ST_CADD,
		ST_MUL,
		ST_UPD,
		ST_DIV,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load_pix;
		logic c_mul;
		logic c_add;
		logic iter_mul;
		logic iter_upd;
		logic fin_esc;
		logic fin_lim;
		logic div_step;
	} cmd_t;

	typedef struct packed {
		logic escape;
		logic limit_hit;
		logic div_last;
	} stat_t;

	// Clamps a wide signed value to the signed Q4.28 word range.
	function automatic logic signed [Q_W-1:0] sat_q(input logic signed [WIDE_W-1:0] v);
		logic signed [Q_W-1:0] r;
		if (v > QMAX) begin
			r = QMAX[Q_W-1:0];
		end else if (v < QMIN) begin
			r = QMIN[Q_W-1:0];
		end else begin
			r = v[Q_W-1:0];
		end
		return r;
	endfunction

endpackage

// ===== sv/mbe_regs.sv =====
// Configuration register file of the Mandelbrot escape-time block.
module mbe_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_we,
	input  logic [mbe_pkg::IDX_W-1:0] cfg_index,
	input  logic [mbe_pkg::Q_W-1:0]   cfg_data,
	output mbe_pkg::cfg_t             cfg
);

	mbe_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.centre_real    <= mbe_pkg::RST_CENTRE_REAL;
			cfg_q.centre_imag    <= mbe_pkg::RST_CENTRE_IMAG;
			cfg_q.pixel_step     <= mbe_pkg::RST_PIXEL_STEP;
			cfg_q.max_iterations <= mbe_pkg::RST_MAX_ITER;
		end else if (cfg_we) begin
			unique case (mbe_pkg::cfg_idx_t'(cfg_index))
				mbe_pkg::REG_CENTRE_REAL: cfg_q.centre_real    <= signed'(cfg_data);
				mbe_pkg::REG_CENTRE_IMAG: cfg_q.centre_imag    <= signed'(cfg_data);
				mbe_pkg::REG_PIXEL_STEP:  cfg_q.pixel_step     <= cfg_data[mbe_pkg::STEP_W-1:0];
				mbe_pkg::REG_MAX_ITER:    cfg_q.max_iterations <= cfg_data[mbe_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== sv/mbe_ctrl.sv =====
// Sequencing state machine of the Mandelbrot escape-time block.
module mbe_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  mbe_pkg::stat_t stat,
	output mbe_pkg::cmd_t  cmd,
	output logic           busy,
	output logic           done
);

	mbe_pkg::state_t state_q;
	mbe_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mbe_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			mbe_pkg::ST_IDLE: begin
				if (start) state_d = mbe_pkg::ST_CMUL;
			end
			mbe_pkg::ST_CMUL: state_d = mbe_pkg::ST_CADD;
			mbe_pkg::ST_CADD: state_d = mbe_pkg::ST_MUL;
			mbe_pkg::ST_MUL: begin
				priority if (stat.escape) begin
					state_d = mbe_pkg::ST_DIV;
				end else if (stat.limit_hit) begin
					state_d = mbe_pkg::ST_DONE;
				end else begin
					state_d = mbe_pkg::ST_UPD;
				end
			end
			mbe_pkg::ST_UPD: state_d = mbe_pkg::ST_MUL;
			mbe_pkg::ST_DIV: begin
				if (stat.div_last) state_d = mbe_pkg::ST_DONE;
			end
			mbe_pkg::ST_DONE: state_d = mbe_pkg::ST_IDLE;
			default: state_d = mbe_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd  = '0;
		busy = 1'b1;
		done = 1'b0;
		unique case (state_q)
			mbe_pkg::ST_IDLE: begin
				busy         = 1'b0;
				cmd.load_pix = start;
			end
			mbe_pkg::ST_CMUL: cmd.c_mul = 1'b1;
			mbe_pkg::ST_CADD: cmd.c_add = 1'b1;
			mbe_pkg::ST_MUL: begin
				priority if (stat.escape) begin
					cmd.fin_esc = 1'b1;
				end else if (stat.limit_hit) begin
					cmd.fin_lim = 1'b1;
				end else begin
					cmd.iter_mul = 1'b1;
				end
			end
			mbe_pkg::ST_UPD:  cmd.iter_upd = 1'b1;
			mbe_pkg::ST_DIV:  cmd.div_step = 1'b1;
			mbe_pkg::ST_DONE: done = 1'b1;
			default: ;
		endcase
	end

endmodule

// ===== sv/mbe_datapath.sv =====
// Datapath: point mapping, complex squaring step and palette divider.
module mbe_datapath (
	input  logic                      clk,
	input  mbe_pkg::cmd_t             cmd,
	input  mbe_pkg::cfg_t             cfg,
	input  logic [mbe_pkg::PIX_W-1:0] column,
	input  logic [mbe_pkg::PIX_W-1:0] row,
	output mbe_pkg::stat_t            stat,
	output logic [mbe_pkg::PIX_W-1:0] column_out,
	output logic [mbe_pkg::PIX_W-1:0] row_out,
	output logic [mbe_pkg::CNT_W-1:0] iteration_count,
	output logic                      escaped,
	output logic [mbe_pkg::CNT_W-1:0] palette_index
);

	logic        [mbe_pkg::PIX_W-1:0]  col_q, row_q;
	logic signed [mbe_pkg::PROD_W-1:0] offr_q, offi_q;
	logic signed [mbe_pkg::Q_W-1:0]    cr_q, ci_q, zr_q, zi_q;
	logic signed [mbe_pkg::P_W-1:0]    p_rr_q, p_ii_q, p_ri_q;
	logic signed [mbe_pkg::XR_W-1:0]   size_q;
	logic        [mbe_pkg::CNT_W-1:0]  count_q, rem_q, pal_q;
	logic        [mbe_pkg::DCNT_W-1:0] dcnt_q;
	logic                              esc_q;

	logic signed [mbe_pkg::OFS_W-1:0]  ofs_r, ofs_i;
	logic signed [mbe_pkg::PROD_W-1:0] step_s;
	logic signed [mbe_pkg::P_W-1:0]    rr_sh, ii_sh, ri_sh;
	logic signed [mbe_pkg::SQ_W-1:0]   r2, i2;
	logic signed [mbe_pkg::XR_W-1:0]   cross_c, size_c;
	logic        [mbe_pkg::CNT_W:0]    count_inc, limit_x, dtrial;
	logic                              dge;

	// Pixel offset from the image centre, in pixel units.
	assign ofs_r  = mbe_pkg::OFS_W'(signed'({1'b0, col_q})) - mbe_pkg::OFS_W'(mbe_pkg::HALF);
	assign ofs_i  = mbe_pkg::OFS_W'(signed'({1'b0, row_q})) - mbe_pkg::OFS_W'(mbe_pkg::HALF);
	assign step_s = mbe_pkg::PROD_W'(signed'({1'b0, cfg.pixel_step}));

	// Floored fixed-point rescale of the registered products.
	assign rr_sh   = p_rr_q >>> mbe_pkg::FRACTION_BITS;
	assign ii_sh   = p_ii_q >>> mbe_pkg::FRACTION_BITS;
	assign ri_sh   = p_ri_q >>> (mbe_pkg::FRACTION_BITS - 1);
	assign r2      = signed'(rr_sh[mbe_pkg::SQ_W-1:0]);
	assign i2      = signed'(ii_sh[mbe_pkg::SQ_W-1:0]);
	assign cross_c = signed'(ri_sh[mbe_pkg::XR_W-1:0]);
	assign size_c  = mbe_pkg::XR_W'(r2) + mbe_pkg::XR_W'(i2);

	assign count_inc = {1'b0, count_q} + (mbe_pkg::CNT_W + 1)'(1);
	assign limit_x   = {1'b0, cfg.max_iterations};

	// One quotient bit per cycle; the partial remainder stays below the limit.
	assign dtrial = {rem_q, 1'b0};
	assign dge    = dtrial >= limit_x;

	always_ff @(posedge clk) begin
		if (cmd.load_pix) begin
			col_q <= column;
			row_q <= row;
		end
		if (cmd.c_mul) begin
			offr_q <= mbe_pkg::PROD_W'(ofs_r) * step_s;
			offi_q <= mbe_pkg::PROD_W'(ofs_i) * step_s;
		end
		if (cmd.c_add) begin
			cr_q    <= mbe_pkg::sat_q(mbe_pkg::WIDE_W'(cfg.centre_real) +
			                          mbe_pkg::WIDE_W'(offr_q));
			ci_q    <= mbe_pkg::sat_q(mbe_pkg::WIDE_W'(cfg.centre_imag) +
			                          mbe_pkg::WIDE_W'(offi_q));
			zr_q    <= '0;
			zi_q    <= '0;
			size_q  <= '0;
			count_q <= '0;
		end
		if (cmd.iter_mul) begin
			count_q <= count_inc[mbe_pkg::CNT_W-1:0];
			p_rr_q  <= mbe_pkg::P_W'(zr_q) * mbe_pkg::P_W'(zr_q);
			p_ii_q  <= mbe_pkg::P_W'(zi_q) * mbe_pkg::P_W'(zi_q);
			p_ri_q  <= mbe_pkg::P_W'(zr_q) * mbe_pkg::P_W'(zi_q);
		end
		if (cmd.iter_upd) begin
			size_q <= size_c;
			zr_q   <= mbe_pkg::sat_q(mbe_pkg::WIDE_W'(r2) - mbe_pkg::WIDE_W'(i2) +
			                         mbe_pkg::WIDE_W'(cr_q));
			zi_q   <= mbe_pkg::sat_q(mbe_pkg::WIDE_W'(cross_c) + mbe_pkg::WIDE_W'(ci_q));
		end
		if (cmd.fin_esc) begin
			esc_q  <= 1'b1;
			rem_q  <= count_q;
			pal_q  <= '0;
			dcnt_q <= '0;
		end
		if (cmd.fin_lim) begin
			esc_q   <= 1'b0;
			count_q <= count_inc[mbe_pkg::CNT_W-1:0];
			pal_q   <= '1;
		end
		if (cmd.div_step) begin
			rem_q  <= dge ? mbe_pkg::CNT_W'(dtrial - limit_x) : dtrial[mbe_pkg::CNT_W-1:0];
			pal_q  <= {pal_q[mbe_pkg::CNT_W-2:0], dge};
			dcnt_q <= dcnt_q + mbe_pkg::DCNT_W'(1);
		end
	end

	assign stat.escape    = mbe_pkg::WIDE_W'(size_q) >= mbe_pkg::FOUR;
	assign stat.limit_hit = count_inc >= limit_x;
	assign stat.div_last  = dcnt_q == mbe_pkg::DIV_LAST;

	assign column_out      = col_q;
	assign row_out         = row_q;
	assign iteration_count = count_q;
	assign escaped         = esc_q;
	assign palette_index   = pal_q;

endmodule

// ===== sv/mandelbrot_escape_time.sv =====
// Top level of the Mandelbrot escape-time pixel evaluator.
// Each iteration registers three parallel products, then adds and clamps;
// an escaped pixel then runs the shift-subtract palette divider.
// One pixel at a time: busy falls after the done beat.
// Reset (arst_n low) returns the sequencer to idle and loads the default view.
module mandelbrot_escape_time (
	input  logic                      clk,
	input  logic                      arst_n,
	// Command channel: a pixel beat is taken when start is high and busy is low.
	input  logic                      start,
	output logic                      busy,
	input  logic [mbe_pkg::PIX_W-1:0] column,
	input  logic [mbe_pkg::PIX_W-1:0] row,
	// Result beat: valid for exactly the one cycle in which done is high.
	output logic                      done,
	output logic [mbe_pkg::PIX_W-1:0] column_out,
	output logic [mbe_pkg::PIX_W-1:0] row_out,
	output logic [mbe_pkg::CNT_W-1:0] iteration_count,
	output logic                      escaped,
	output logic [mbe_pkg::CNT_W-1:0] palette_index,
	// Register write port; write only while idle, as the block does not enforce it.
	input  logic                      cfg_we,
	input  logic [mbe_pkg::IDX_W-1:0] cfg_index,
	input  logic [mbe_pkg::Q_W-1:0]   cfg_data
);

	mbe_pkg::cfg_t  cfg;
	mbe_pkg::cmd_t  cmd;
	mbe_pkg::stat_t stat;

	// View registers: centre point, pixel pitch and iteration limit.
	mbe_regs u_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// The sequencer maps the pixel to c, runs the z*z + c loop until the point
	// escapes or the count reaches the limit, and then derives the palette
	// index, dividing only when the point escaped below the limit.
	mbe_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	// All arithmetic and the result registers live in the datapath; the
	// result registers hold their values after the done beat until the next pixel.
	mbe_datapath u_dp (
		.clk             (clk),
		.cmd             (cmd),
		.cfg             (cfg),
		.column          (column),
		.row             (row),
		.stat            (stat),
		.column_out      (column_out),
		.row_out         (row_out),
		.iteration_count (iteration_count),
		.escaped         (escaped),
		.palette_index   (palette_index)
	);

endmodule

// ===== sv/mbe_checker.sv =====
// Port-level checks of the command handshake of the escape-time block.
module mbe_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done
);

	a_done_busy: assert property (@(posedge clk) disable iff (!arst_n) done |-> busy)
		else $error("done beat outside a busy period");

	a_done_single: assert property (@(posedge clk) disable iff (!arst_n) done |=> !done)
		else $error("done beat lasted more than one cycle");

	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted pixel did not raise busy");

	a_busy_hold: assert property (@(posedge clk) disable iff (!arst_n)
		busy && !done |=> busy)
		else $error("busy fell without a done beat");

	a_done_free: assert property (@(posedge clk) disable iff (!arst_n) done |=> !busy)
		else $error("block stayed busy after the done beat");

endmodule

bind mandelbrot_escape_time mbe_checker u_mbe_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.start  (start),
	.busy   (busy),
	.done   (done)
);
